[rtl/urbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbp_pkg
// Shared constants and types for the UART ring buffer pair.
// ----------------------------------------------------------------------------
package urbp_pkg;

   localparam int RX_DEPTH  = 16;
   localparam int TX_DEPTH  = 16;
   localparam int RX_PTR_W  = $clog2(RX_DEPTH);
   localparam int TX_PTR_W  = $clog2(TX_DEPTH);
   localparam int BYTE_W    = 8;
   localparam int OPCODE_W  = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_TX_READY = 2'd1,
      OP_PUT      = 2'd2,
      OP_GET      = 2'd3
   } opcode_type;

   typedef struct packed {
      logic                wr_en;
      logic [RX_PTR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]   wr_data;
      logic                rd_en;
      logic [RX_PTR_W-1:0] rd_addr;
   } rx_ram_req_type;

   typedef struct packed {
      logic                wr_en;
      logic [TX_PTR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]   wr_data;
      logic                rd_en;
      logic [TX_PTR_W-1:0] rd_addr;
   } tx_ram_req_type;

endpackage

[rtl/urbp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module urbp_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/urbp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbp_ctrl
// Ring pointers, interrupt-enable flags, operation sequencing, result register.
// ----------------------------------------------------------------------------
module urbp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [urbp_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [urbp_pkg::BYTE_W-1:0]     req_byte_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_done_res,
   output logic [urbp_pkg::BYTE_W-1:0]     rsp_byte_out,
   output logic                            rsp_rx_irq_enable,
   output logic                            rsp_tx_irq_enable,
   output urbp_pkg::rx_ram_req_type        rx_ram_req,
   input  logic [urbp_pkg::BYTE_W-1:0]     rx_rd_data,
   output urbp_pkg::tx_ram_req_type        tx_ram_req,
   input  logic [urbp_pkg::BYTE_W-1:0]     tx_rd_data
);

   import urbp_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic done;
      logic rd;
      logic sel_rx;
   } pend_type;

   state_type           state_ff;
   logic [RX_PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic                rx_flag_ff, rx_flag_in, tx_flag_ff, tx_flag_in;
   pend_type            pend_ff, pend_in;
   logic                rsp_valid_ff;
   logic                rsp_done_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_rx_irq_ff, rsp_tx_irq_ff;

   logic                accept, finish;
   logic [RX_PTR_W-1:0] rx_tail_nxt, rx_head_nxt;
   logic [TX_PTR_W-1:0] tx_tail_nxt, tx_head_nxt;
   logic                rx_full, rx_empty, tx_full, tx_empty;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // wrap pointers at the ring depth
   assign rx_tail_nxt = (rx_tail_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;
   assign rx_head_nxt = (rx_head_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head_ff + 1'b1;
   assign tx_tail_nxt = (tx_tail_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + 1'b1;
   assign tx_head_nxt = (tx_head_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;

   assign rx_full  = (rx_tail_nxt == rx_head_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (tx_tail_nxt == tx_head_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);

   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      rx_flag_in = rx_flag_ff;
      tx_flag_in = tx_flag_ff;
      pend_in    = pend_ff;

      rx_ram_req         = '0;
      rx_ram_req.wr_addr = rx_tail_ff;
      rx_ram_req.wr_data = req_byte_in;
      rx_ram_req.rd_addr = rx_head_ff;
      tx_ram_req         = '0;
      tx_ram_req.wr_addr = tx_tail_ff;
      tx_ram_req.wr_data = req_byte_in;
      tx_ram_req.rd_addr = tx_head_ff;

      if (accept) begin
         pend_in = '0;
         case (opcode_type'(req_opcode))
            OP_RX_BYTE: begin
               if (rx_full) begin
                  rx_flag_in = 1'b0;
               end else begin
                  rx_ram_req.wr_en = 1'b1;
                  rx_tail_in       = rx_tail_nxt;
                  pend_in.done     = 1'b1;
               end
            end
            OP_TX_READY: begin
               if (tx_empty) begin
                  tx_flag_in = 1'b0;
               end else begin
                  tx_ram_req.rd_en = 1'b1;
                  tx_head_in       = tx_head_nxt;
                  pend_in.done     = 1'b1;
                  pend_in.rd       = 1'b1;
               end
            end
            OP_PUT: begin
               if (!tx_full) begin
                  tx_ram_req.wr_en = 1'b1;
                  tx_tail_in       = tx_tail_nxt;
                  tx_flag_in       = 1'b1;
                  pend_in.done     = 1'b1;
               end
            end
            OP_GET: begin
               if (rx_empty) begin
                  rx_flag_in = 1'b1;
               end else begin
                  rx_ram_req.rd_en = 1'b1;
                  rx_head_in       = rx_head_nxt;
                  pend_in.done     = 1'b1;
                  pend_in.rd       = 1'b1;
                  pend_in.sel_rx   = 1'b1;
               end
            end
            default: begin
               pend_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_byte_in = '0;
      if (pend_ff.rd) begin
         rsp_byte_in = pend_ff.sel_rx ? rx_rd_data : tx_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         rx_flag_ff   <= 1'b1;
         tx_flag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         rx_flag_ff <= rx_flag_in;
         tx_flag_ff <= tx_flag_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_FINISH;
               end
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_FINISH: begin
               if (finish) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (finish) begin
         rsp_done_ff   <= pend_ff.done;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_rx_irq_ff <= rx_flag_ff;
         rsp_tx_irq_ff <= tx_flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_byte_out      = rsp_byte_ff;
   assign rsp_rx_irq_enable = rsp_rx_irq_ff;
   assign rsp_tx_irq_enable = rsp_tx_irq_ff;

endmodule

[rtl/uart_ring_buffer_pair_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_core
// Receive and transmit byte rings with interrupt-enable flags.
// ----------------------------------------------------------------------------
// Each request is one of four operations: store a byte received from the
// line, hand the oldest transmit byte to the line, queue a byte for transmit
// (put), or fetch the oldest received byte (get). Every request yields exactly
// one response carrying a done bit, the byte read out (zero when nothing was
// read) and the receive and transmit interrupt enables after the operation.
// Each ring keeps one slot free, so it holds at most depth minus one bytes.
// In the request transfer cycle the pointers and flags update and the ring
// RAM is written or read; the registered RAM read data is then loaded into
// the response register in the finish state, which raises response valid,
// once any earlier response still waiting has transferred. A new request is
// taken once the response register has been loaded, while that response may
// still wait for its transfer. No clearing pass follows reset: ring entries
// are only read after they have been written.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [urbp_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [urbp_pkg::BYTE_W-1:0]   req_byte_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_done_res,
   output logic [urbp_pkg::BYTE_W-1:0]   rsp_byte_out,
   output logic                          rsp_rx_irq_enable,
   output logic                          rsp_tx_irq_enable
);

   import urbp_pkg::*;

   rx_ram_req_type    rx_ram_req;
   tx_ram_req_type    tx_ram_req;
   logic [BYTE_W-1:0] rx_rd_data;
   logic [BYTE_W-1:0] tx_rd_data;

   // sequencing, pointers and flags; one ring access per operation, so a
   // write and a read of the same entry never fall in the same cycle
   urbp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_byte_in       (req_byte_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_done_res      (rsp_done_res),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_rx_irq_enable (rsp_rx_irq_enable),
      .rsp_tx_irq_enable (rsp_tx_irq_enable),
      .rx_ram_req        (rx_ram_req),
      .rx_rd_data        (rx_rd_data),
      .tx_ram_req        (tx_ram_req),
      .tx_rd_data        (tx_rd_data)
   );

   // receive ring storage
   urbp_ram #(
      .DEPTH (RX_DEPTH),
      .WIDTH (BYTE_W)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_ram_req.wr_en),
      .wr_addr (rx_ram_req.wr_addr),
      .wr_data (rx_ram_req.wr_data),
      .rd_en   (rx_ram_req.rd_en),
      .rd_addr (rx_ram_req.rd_addr),
      .rd_data (rx_rd_data)
   );

   // transmit ring storage
   urbp_ram #(
      .DEPTH (TX_DEPTH),
      .WIDTH (BYTE_W)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_ram_req.wr_en),
      .wr_addr (tx_ram_req.wr_addr),
      .wr_data (tx_ram_req.wr_data),
      .rd_en   (tx_ram_req.rd_en),
      .rd_addr (tx_ram_req.rd_addr),
      .rd_data (tx_rd_data)
   );

endmodule

[rtl/urbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbp_checker
// Port-level checks for the UART ring buffer pair, bound to the top level.
// ----------------------------------------------------------------------------
module urbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_done_res,
   input logic [urbp_pkg::BYTE_W-1:0]   rsp_byte_out,
   input logic                          rsp_rx_irq_enable,
   input logic                          rsp_tx_irq_enable
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res)
         && $stable(rsp_byte_out) && $stable(rsp_rx_irq_enable)
         && $stable(rsp_tx_irq_enable))
      else $error("response changed while stalled");

   // nothing moved means a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_byte_out == '0)
      else $error("byte_out nonzero without done");

   // one operation in flight: no request taken right after a transfer
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every response follows a request transfer or is held
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(!req_ready, 2))
      else $error("response without a request");

endmodule

bind uart_ring_buffer_pair_core urbp_checker u_checker (.*);
